@@ src/sfl_pkg.sv @@
// ----------------------------------------------------------------------------
// sfl_pkg: shared types and constants of the stereo flanger
// widths of the sample, sweep and gain formats, register indexes, reset values
// and the packed item types of both channels
// ----------------------------------------------------------------------------
`default_nettype none

package sfl_pkg;

    // sample and fixed point formats
    localparam int SAMPLE_W   = 24;
    localparam int FRAC_W     = 16;
    localparam int GAIN_W     = 15;
    localparam int STEP_W     = 16;
    localparam int LEN_CFG_W  = 10;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN     = 2'd2;

    localparam int LEN_RESET  = 350;
    localparam int STEP_RESET = 131;
    localparam int GAIN_RESET = 22938;

    localparam int DELAY_MAX_DEFAULT = 512;

    // datapath widths
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int DF_W   = DIFF_W + FRAC_W + 1;
    localparam int SUM_W  = SAMPLE_W + 2;
    localparam int PROD_W = SUM_W + GAIN_W + 1;
    localparam int Q_W    = PROD_W - GAIN_W;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } sfl_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } sfl_out_t;

    // one delay store entry
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } sfl_pair_t;

    // stage enables of the channel datapath
    typedef struct packed {
        logic mix;
        logic sum;
        logic gain;
    } sfl_stage_t;

endpackage

`default_nettype wire

@@ src/sfl_store.sv @@
// ----------------------------------------------------------------------------
// sfl_store: delay store of left/right pairs
// one write port and two registered read ports, with a clearing pass after
// reset that zeroes every entry one per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sfl_store #(
    parameter int DEPTH = sfl_pkg::DELAY_MAX_DEFAULT
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    output logic                           clr_busy,
    input  wire logic                      rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr1,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr2,
    output sfl_pkg::sfl_pair_t             rd_data1,
    output sfl_pkg::sfl_pair_t             rd_data2,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire sfl_pkg::sfl_pair_t        wr_data
);

    localparam int ADDR_W = $clog2(DEPTH);

    sfl_pkg::sfl_pair_t mem [DEPTH];
    sfl_pkg::sfl_pair_t rd1_reg;
    sfl_pkg::sfl_pair_t rd2_reg;

    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd1_reg <= mem[rd_addr1];
            rd2_reg <= mem[rd_addr2];
        end
    end

    assign clr_busy = clr_busy_reg;
    assign rd_data1 = rd1_reg;
    assign rd_data2 = rd2_reg;

endmodule

`default_nettype wire

@@ src/sfl_chan.sv @@
// ----------------------------------------------------------------------------
// sfl_chan: arithmetic of one channel
// interpolates two neighbouring entries, adds the input, scales by the mix
// gain and rounds and saturates to the sample range
// ----------------------------------------------------------------------------
`default_nettype none

module sfl_chan (
    input  wire logic                                   aclk,
    input  wire sfl_pkg::sfl_stage_t                    stage,
    input  wire logic signed [sfl_pkg::SAMPLE_W-1:0]    rd_a,
    input  wire logic signed [sfl_pkg::SAMPLE_W-1:0]    rd_b,
    input  wire logic signed [sfl_pkg::SAMPLE_W-1:0]    x,
    input  wire logic [sfl_pkg::FRAC_W-1:0]             frac,
    input  wire logic [sfl_pkg::GAIN_W-1:0]             gain,
    output logic signed [sfl_pkg::SAMPLE_W-1:0]         y
);

    localparam int SW = sfl_pkg::SAMPLE_W;
    localparam int FW = sfl_pkg::FRAC_W;
    localparam int DW = sfl_pkg::DIFF_W;
    localparam int DFW = sfl_pkg::DF_W;
    localparam int SUMW = sfl_pkg::SUM_W;
    localparam int PW = sfl_pkg::PROD_W;
    localparam int QW = sfl_pkg::Q_W;
    localparam int GW = sfl_pkg::GAIN_W;

    localparam logic signed [QW-1:0] SAT_HI = QW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] SAT_LO = QW'(-(64'sd1 <<< (SW - 1)));

    logic signed [SW-1:0]   a_reg;
    logic signed [DFW-1:0]  df_reg;
    logic signed [DFW-1:0]  df_next;
    logic signed [SUMW-1:0] sum_reg;
    logic signed [SUMW-1:0] sum_next;
    logic signed [PW-1:0]   prod_reg;
    logic signed [PW-1:0]   prod_next;

    logic signed [DW-1:0]   diff;
    logic signed [FW:0]     frac_s;
    logic signed [DFW-1:0]  mix;
    logic signed [DW-1:0]   blend;
    logic signed [GW:0]     gain_s;
    logic signed [PW-1:0]   rnd;
    logic signed [QW-1:0]   q;

    // b*f + a*(1-f) as a + (b-a)*f
    always_comb begin
        diff    = DW'(rd_b) - DW'(rd_a);
        frac_s  = $signed({1'b0, frac});
        df_next = diff * frac_s;
    end

    always_comb begin
        mix      = (DFW'(a_reg) <<< FW) + df_reg + DFW'(1 << (FW - 1));
        blend    = $signed(mix[FW+DW-1:FW]);
        sum_next = SUMW'(x) + SUMW'(blend);
    end

    always_comb begin
        gain_s    = $signed({1'b0, gain});
        prod_next = sum_reg * gain_s;
    end

    always_comb begin
        rnd = prod_reg + PW'(1 << (GW - 1));
        q   = $signed(rnd[PW-1:GW]);
        if (q > SAT_HI) begin
            y = SW'(SAT_HI);
        end else if (q < SAT_LO) begin
            y = SW'(SAT_LO);
        end else begin
            y = SW'(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage.mix) begin
            a_reg  <= rd_a;
            df_reg <= df_next;
        end
        if (stage.sum) begin
            sum_reg <= sum_next;
        end
        if (stage.gain) begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

@@ src/stereo_flanger.sv @@
// ----------------------------------------------------------------------------
// stereo_flanger: stereo flanger with a swept, interpolated delay
// each item on s_data is one stereo pair; one flanged pair comes back on
// m_data for every item, in order, with valid/ready on both sides.
// an item is taken when s_valid and s_ready are high; the result appears on
// m_valid after the states MIX, SUM, GAIN and OUT, and the next item is only
// taken once the block is back in its idle state. the delay store is read at
// the accepting edge, then come the interpolation multiply, the sum, the gain
// multiply and the rounding into the output register, one item at a time.
// the result sits in an output register, so the next item is taken while it
// waits; a stalled receiver holds the block only once a second result is
// ready. after reset the delay store is zeroed in a pass during which s_ready
// stays low; configuration writes are taken at any time and must only be
// issued while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_flanger #(
    parameter int DELAY_MAX = sfl_pkg::DELAY_MAX_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire sfl_pkg::sfl_in_t                   s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output sfl_pkg::sfl_out_t                       m_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [sfl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sfl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ADDR_W = $clog2(DELAY_MAX);
    localparam int LEN_W  = $clog2(DELAY_MAX + 1);
    localparam int FW     = sfl_pkg::FRAC_W;
    localparam int POS_W  = ADDR_W + FW;
    localparam int PSUM_W = LEN_W + 1;
    localparam int LEN_RST_EFF = (sfl_pkg::LEN_RESET < 2) ? 2 :
                                 ((sfl_pkg::LEN_RESET > DELAY_MAX) ? DELAY_MAX :
                                  sfl_pkg::LEN_RESET);
    localparam logic [POS_W-1:0] POS_RESET = POS_W'((LEN_RST_EFF / 2) << FW);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MIX  = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_GAIN = 5'b01000,
        ST_OUT  = 5'b10000
    } sfl_state_t;

    sfl_state_t state_reg;
    sfl_state_t state_next;

    logic [sfl_pkg::LEN_CFG_W-1:0] len_cfg_reg;
    logic [sfl_pkg::STEP_W-1:0]    step_reg;
    logic [sfl_pkg::GAIN_W-1:0]    gain_reg;

    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] wp_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              falling_reg;
    logic              falling_next;

    sfl_pkg::sfl_in_t  in_reg;
    logic [FW-1:0]     frac_reg;
    logic [ADDR_W-1:0] wr_addr_reg;

    logic              m_valid_reg;
    logic              m_valid_next;
    sfl_pkg::sfl_out_t m_data_reg;

    logic [LEN_W-1:0]  len_eff;
    logic [POS_W-1:0]  top_pos;
    logic [POS_W-1:0]  pos_c;
    logic [ADDR_W-1:0] wp_eff;
    logic [PSUM_W-1:0] p1_sum;
    logic [ADDR_W-1:0] p1;
    logic [LEN_W-1:0]  p2_sum;
    logic [ADDR_W-1:0] p2;
    logic [LEN_W-1:0]  wp_inc;
    logic [POS_W:0]    pos_up;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic              clr_busy;
    sfl_pkg::sfl_pair_t rd_data1;
    sfl_pkg::sfl_pair_t rd_data2;
    sfl_pkg::sfl_pair_t wr_pair;
    sfl_pkg::sfl_stage_t stage;
    logic signed [sfl_pkg::SAMPLE_W-1:0] y_left;
    logic signed [sfl_pkg::SAMPLE_W-1:0] y_right;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg <= sfl_pkg::LEN_CFG_W'(sfl_pkg::LEN_RESET);
            step_reg    <= sfl_pkg::STEP_W'(sfl_pkg::STEP_RESET);
            gain_reg    <= sfl_pkg::GAIN_W'(sfl_pkg::GAIN_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sfl_pkg::CFG_DELAY_LENGTH: begin
                    len_cfg_reg <= cfg_data[sfl_pkg::LEN_CFG_W-1:0];
                end
                sfl_pkg::CFG_SWEEP_STEP: begin
                    step_reg <= cfg_data[sfl_pkg::STEP_W-1:0];
                end
                sfl_pkg::CFG_MIX_GAIN: begin
                    gain_reg <= cfg_data[sfl_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective length, pointers and sweep
    always_comb begin
        if (len_cfg_reg < sfl_pkg::LEN_CFG_W'(2)) begin
            len_eff = LEN_W'(2);
        end else if (32'(len_cfg_reg) > DELAY_MAX) begin
            len_eff = LEN_W'(DELAY_MAX);
        end else begin
            len_eff = LEN_W'(len_cfg_reg);
        end

        top_pos = {ADDR_W'(len_eff - LEN_W'(1)), {FW{1'b0}}};
        pos_c   = (pos_reg > top_pos) ? top_pos : pos_reg;
        wp_eff  = (LEN_W'(wp_reg) >= len_eff) ? '0 : wp_reg;

        p1_sum = PSUM_W'(wp_eff) + PSUM_W'(pos_c[POS_W-1:FW]);
        if (p1_sum >= PSUM_W'(len_eff)) begin
            p1_sum = p1_sum - PSUM_W'(len_eff);
        end
        p1 = p1_sum[ADDR_W-1:0];

        p2_sum = LEN_W'(p1) + LEN_W'(1);
        p2     = (p2_sum >= len_eff) ? '0 : p2_sum[ADDR_W-1:0];

        wp_inc = LEN_W'(wp_eff) + LEN_W'(1);
        pos_up = (POS_W + 1)'(pos_c) + (POS_W + 1)'(step_reg);
    end

    always_comb begin
        wp_next      = wp_reg;
        pos_next     = pos_reg;
        falling_next = falling_reg;
        if (accept) begin
            wp_next  = (wp_inc >= len_eff) ? '0 : wp_inc[ADDR_W-1:0];
            pos_next = pos_c;
            if (falling_reg) begin
                if (POS_W'(step_reg) > pos_c) begin
                    falling_next = 1'b0;
                end else begin
                    pos_next = pos_c - POS_W'(step_reg);
                end
            end else begin
                if (pos_up > (POS_W + 1)'(top_pos)) begin
                    falling_next = 1'b1;
                end else begin
                    pos_next = pos_up[POS_W-1:0];
                end
            end
        end
    end

    // control
    assign s_ready  = (state_reg == ST_IDLE) && !clr_busy;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            pos_reg     <= POS_RESET;
            falling_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            pos_reg     <= pos_next;
            falling_reg <= falling_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // item payload held while it is worked on
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg      <= s_data;
            frac_reg    <= pos_c[FW-1:0];
            wr_addr_reg <= wp_eff;
        end
        if (out_load) begin
            m_data_reg.left_out  <= y_left;
            m_data_reg.right_out <= y_right;
        end
    end

    assign stage.mix  = (state_reg == ST_MIX);
    assign stage.sum  = (state_reg == ST_SUM);
    assign stage.gain = (state_reg == ST_GAIN);

    assign wr_pair.left  = in_reg.left_sample;
    assign wr_pair.right = in_reg.right_sample;

    // store is read at accept and written back in the following cycle
    sfl_store #(
        .DEPTH (DELAY_MAX)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clr_busy (clr_busy),
        .rd_en    (accept),
        .rd_addr1 (p1),
        .rd_addr2 (p2),
        .rd_data1 (rd_data1),
        .rd_data2 (rd_data2),
        .wr_en    (stage.mix),
        .wr_addr  (wr_addr_reg),
        .wr_data  (wr_pair)
    );

    sfl_chan u_chan_left (
        .aclk  (aclk),
        .stage (stage),
        .rd_a  (rd_data1.left),
        .rd_b  (rd_data2.left),
        .x     (in_reg.left_sample),
        .frac  (frac_reg),
        .gain  (gain_reg),
        .y     (y_left)
    );

    sfl_chan u_chan_right (
        .aclk  (aclk),
        .stage (stage),
        .rd_a  (rd_data1.right),
        .rd_b  (rd_data2.right),
        .x     (in_reg.right_sample),
        .frac  (frac_reg),
        .gain  (gain_reg),
        .y     (y_right)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // no item taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("item accepted during store clear");

    // sweep never left beyond the top of the current length
    a_sweep_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (pos_reg <= $past(top_pos)))
        else $error("sweep position beyond delay length");

    // write-back only in the cycle after an accepted item
    a_write_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        stage.mix |-> $past(accept))
        else $error("store write without a preceding read");

endmodule

`default_nettype wire

@@ tb/sv/tb_stereo_flanger.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_flanger: self-checking bench for the stereo flanger
// stereo pairs are streamed in through bursts and gaps against a stalling
// receiver, over a series of delay length, sweep step and gain settings.
// a bit-true predictor keeps its own delay store and sweep, and every
// returned pair is compared against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_stereo_flanger;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 450;
    localparam int LONG_HOLD    = 90;
    localparam logic [sfl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    sfl_pkg::sfl_in_t               s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    sfl_pkg::sfl_out_t              m_data;
    logic                           cfg_wr_en = 1'b0;
    logic [sfl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sfl_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    stereo_flanger dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // predictor state
    logic signed [sfl_pkg::SAMPLE_W-1:0] hist_left  [sfl_pkg::DELAY_MAX_DEFAULT];
    logic signed [sfl_pkg::SAMPLE_W-1:0] hist_right [sfl_pkg::DELAY_MAX_DEFAULT];
    int unsigned                         wr_pos;
    int unsigned                         sweep_pos;
    bit                                  sweep_down;
    logic [sfl_pkg::LEN_CFG_W-1:0]       len_reg;
    logic [sfl_pkg::STEP_W-1:0]          step_reg;
    logic [sfl_pkg::GAIN_W-1:0]          gain_reg;

    sfl_pkg::sfl_in_t  pending_pairs [$];
    sfl_pkg::sfl_out_t flanged_due   [$];

    bit s_took = 1'b0;
    bit long_hold_req = 1'b0;
    bit long_hold_seen = 1'b0;
    int long_hold_cnt = 0;
    int tx_burst = 0;
    int tx_gap = 0;
    int rx_cnt = 0;
    int rx_mode = 0;
    int fails = 0;
    int n_in = 0;
    int n_out = 0;
    int n_sat = 0;
    int n_settings = 0;

    function automatic logic signed [sfl_pkg::SAMPLE_W-1:0] flange_one(
        input longint x, input longint a, input longint b, input longint f);
        longint mixv;
        longint blend;
        longint prod;
        longint q;
        mixv  = a * (65536 - f) + b * f + 32768;
        blend = mixv >>> 16;
        prod  = (x + blend) * longint'(gain_reg) + 16384;
        q     = prod >>> 15;
        if (q > 64'sd8388607) begin
            q = 8388607;
            n_sat++;
        end else if (q < -64'sd8388608) begin
            q = -8388608;
            n_sat++;
        end
        return q[sfl_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic sfl_pkg::sfl_out_t flange_pair(input sfl_pkg::sfl_in_t x);
        int unsigned       len;
        int unsigned       top;
        int unsigned       wp;
        int unsigned       ip;
        int unsigned       frac;
        int unsigned       p1;
        int unsigned       p2;
        int unsigned       nxt;
        sfl_pkg::sfl_out_t y;
        if (len_reg < 2)
            len = 2;
        else if (len_reg > sfl_pkg::DELAY_MAX_DEFAULT)
            len = sfl_pkg::DELAY_MAX_DEFAULT;
        else
            len = len_reg;
        top = (len - 1) << 16;
        wp  = (wr_pos >= len) ? 0 : wr_pos;
        if (sweep_pos > top)
            sweep_pos = top;
        ip   = sweep_pos >> 16;
        frac = sweep_pos & 32'hFFFF;
        p1   = wp + ip;
        if (p1 >= len)
            p1 = p1 - len;
        p2 = (p1 + 1 >= len) ? 0 : p1 + 1;
        y.left_out  = flange_one(x.left_sample, hist_left[p1], hist_left[p2], frac);
        y.right_out = flange_one(x.right_sample, hist_right[p1], hist_right[p2], frac);
        hist_left[wp]  = x.left_sample;
        hist_right[wp] = x.right_sample;
        wr_pos = (wp + 1 >= len) ? 0 : wp + 1;
        if (sweep_down) begin
            if (step_reg > sweep_pos)
                sweep_down = 1'b0;
            else
                sweep_pos = sweep_pos - step_reg;
        end else begin
            nxt = sweep_pos + step_reg;
            if (nxt > top)
                sweep_down = 1'b1;
            else
                sweep_pos = nxt;
        end
        return y;
    endfunction

    // sender: bursts of items with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (tx_gap > 0) begin
                tx_gap  <= tx_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                s_data  <= pending_pairs.pop_front();
                s_valid <= 1'b1;
                if (tx_burst == 0) begin
                    tx_burst <= $urandom_range(1, 16);
                    tx_gap   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    tx_burst <= tx_burst - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern plus one long hold on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_hold_cnt > 0) begin
            long_hold_cnt <= long_hold_cnt - 1;
            m_ready       <= 1'b0;
        end else if (long_hold_req && !long_hold_seen) begin
            long_hold_seen <= 1'b1;
            long_hold_cnt  <= LONG_HOLD;
            m_ready        <= 1'b0;
        end else begin
            rx_cnt <= rx_cnt + 1;
            if (rx_cnt % 50 == 49)
                rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= $urandom_range(0, 1);
                2:       m_ready <= (rx_cnt % 4 == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // monitor: register writes, prediction and result checking
    always @(posedge aclk) begin
        sfl_pkg::sfl_out_t want;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_valid && s_ready;
            if (cfg_wr_en) begin
                case (cfg_index)
                    sfl_pkg::CFG_DELAY_LENGTH: len_reg  = cfg_data[sfl_pkg::LEN_CFG_W-1:0];
                    sfl_pkg::CFG_SWEEP_STEP:   step_reg = cfg_data[sfl_pkg::STEP_W-1:0];
                    sfl_pkg::CFG_MIX_GAIN:     gain_reg = cfg_data[sfl_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                flanged_due.push_back(flange_pair(s_data));
                n_in++;
            end
            if (m_valid && m_ready) begin
                n_out++;
                if (flanged_due.size() == 0) begin
                    $error("unexpected item on m_data: %h", m_data);
                    fails++;
                end else begin
                    want = flanged_due.pop_front();
                    if (m_data.left_out !== want.left_out) begin
                        $error("left_out: expected %0d, got %0d", want.left_out, m_data.left_out);
                        fails++;
                    end
                    if (m_data.right_out !== want.right_out) begin
                        $error("right_out: expected %0d, got %0d",
                               want.right_out, m_data.right_out);
                        fails++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    function automatic logic signed [sfl_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return '0;
            3:       return sfl_pkg::SAMPLE_W'($urandom_range(0, 511) - 256);
            4:       return sfl_pkg::SAMPLE_W'($urandom_range(0, 24'h7FFFFF));
            default: return sfl_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic push_pair(input logic [sfl_pkg::SAMPLE_W-1:0] l,
                             input logic [sfl_pkg::SAMPLE_W-1:0] r);
        pending_pairs.push_back(sfl_pkg::sfl_in_t'{l, r});
    endtask

    task automatic write_reg(input logic [sfl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sfl_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || s_valid || flanged_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_setting();
        logic [sfl_pkg::LEN_CFG_W-1:0] len;
        logic [sfl_pkg::STEP_W-1:0]    step;
        logic [sfl_pkg::GAIN_W-1:0]    gain;
        case ($urandom_range(0, 7))
            0:       len = sfl_pkg::LEN_CFG_W'($urandom_range(0, 1));
            1:       len = sfl_pkg::LEN_CFG_W'(2);
            2:       len = sfl_pkg::LEN_CFG_W'($urandom_range(3, 8));
            3:       len = sfl_pkg::LEN_CFG_W'($urandom_range(9, 64));
            4:       len = sfl_pkg::LEN_CFG_W'($urandom_range(2, 512));
            5:       len = sfl_pkg::LEN_CFG_W'(512);
            6:       len = sfl_pkg::LEN_CFG_W'($urandom_range(513, 1023));
            default: len = sfl_pkg::LEN_CFG_W'($urandom_range(300, 511));
        endcase
        case ($urandom_range(0, 4))
            0:       step = '0;
            1:       step = 16'hFFFF;
            2:       step = sfl_pkg::STEP_W'($urandom_range(1, 255));
            3:       step = sfl_pkg::STEP_W'($urandom_range(256, 8191));
            default: step = sfl_pkg::STEP_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       gain = '0;
            1:       gain = 15'h7FFF;
            default: gain = sfl_pkg::GAIN_W'($urandom);
        endcase
        if ($urandom_range(0, 3) != 0)
            write_reg(sfl_pkg::CFG_DELAY_LENGTH, {6'($urandom), len});
        if ($urandom_range(0, 3) != 0)
            write_reg(sfl_pkg::CFG_SWEEP_STEP, step);
        if ($urandom_range(0, 3) != 0)
            write_reg(sfl_pkg::CFG_MIX_GAIN, {1'($urandom), gain});
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_UNUSED, 16'($urandom));
    endtask

    initial begin
        int phase;
        int n;
        int sent;
        for (int i = 0; i < sfl_pkg::DELAY_MAX_DEFAULT; i++) begin
            hist_left[i]  = '0;
            hist_right[i] = '0;
        end
        wr_pos     = 0;
        sweep_pos  = (sfl_pkg::LEN_RESET / 2) << 16;
        sweep_down = 1'b0;
        len_reg    = sfl_pkg::LEN_CFG_W'(sfl_pkg::LEN_RESET);
        step_reg   = sfl_pkg::STEP_W'(sfl_pkg::STEP_RESET);
        gain_reg   = sfl_pkg::GAIN_W'(sfl_pkg::GAIN_RESET);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings, sample extremes and bit patterns
        push_pair(24'h7FFFFF, 24'h800000);
        push_pair(24'h800000, 24'h7FFFFF);
        push_pair(24'h000000, 24'h000000);
        push_pair(24'hFFFFFF, 24'h000001);
        push_pair(24'hAAAAAA, 24'h555555);
        push_pair(24'h555555, 24'hAAAAAA);
        wait_idle();

        // length below range, largest step and gain; sweep and pointer past the new length
        write_reg(sfl_pkg::CFG_DELAY_LENGTH, 16'h0000);
        write_reg(sfl_pkg::CFG_SWEEP_STEP, 16'hFFFF);
        write_reg(sfl_pkg::CFG_MIX_GAIN, 16'h7FFF);
        push_pair(24'h7FFFFF, 24'h7FFFFF);
        push_pair(24'h7FFFFF, 24'h800000);
        push_pair(24'h800000, 24'h800000);
        push_pair(24'h800000, 24'h7FFFFF);
        push_pair(24'h7FFFFF, 24'h800000);
        push_pair(24'h123456, 24'hEDCBA9);
        wait_idle();

        // zero step, zero gain, unknown register
        write_reg(sfl_pkg::CFG_DELAY_LENGTH, 16'h0001);
        write_reg(sfl_pkg::CFG_SWEEP_STEP, 16'h0000);
        write_reg(sfl_pkg::CFG_MIX_GAIN, 16'h8000);
        write_reg(CFG_UNUSED, 16'hFFFF);
        push_pair(24'h7FFFFF, 24'h800000);
        push_pair(24'h400000, 24'hC00000);
        push_pair(24'hFFFFFF, 24'h000001);
        wait_idle();

        // length above range, half gain
        write_reg(sfl_pkg::CFG_DELAY_LENGTH, 16'hFFFF);
        write_reg(sfl_pkg::CFG_SWEEP_STEP, 16'hFFFF);
        write_reg(sfl_pkg::CFG_MIX_GAIN, 16'h4000);
        for (int i = 0; i < 8; i++)
            push_pair(rand_sample(), rand_sample());
        wait_idle();

        // shrink below the write pointer and the sweep position
        write_reg(sfl_pkg::CFG_DELAY_LENGTH, 16'h0003);
        write_reg(sfl_pkg::CFG_SWEEP_STEP, 16'd40000);
        write_reg(sfl_pkg::CFG_MIX_GAIN, 16'h7FFF);
        for (int i = 0; i < 4; i++)
            push_pair(rand_sample(), rand_sample());
        wait_idle();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            random_setting();
            n = $urandom_range(25, 50);
            for (int i = 0; i < n; i++)
                push_pair(rand_sample(), rand_sample());
            sent += n;
            if (phase == 2)
                long_hold_req <= 1'b1;
            wait_idle();
            phase++;
        end

        repeat (20) @(posedge aclk);
        $display("tb: %0d items in, %0d results checked, %0d register writes",
                 n_in, n_out, n_settings);
        $display("tb: %0d saturated samples, %0d random setting phases", n_sat, phase);
        if (fails == 0 && flanged_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
